// ===== hw/rtl/fpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpcc_pkg: shared types and constants for the framed packet CRC checker
// Holds the verdict codes, the byte kinds passed from front to back, the
// queue entry and configuration structs, and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package fpcc_pkg;

    // Verdict codes
    localparam logic [2:0] ST_VALID      = 3'd0;
    localparam logic [2:0] ST_BAD_START  = 3'd1;
    localparam logic [2:0] ST_BAD_ID     = 3'd2;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
    localparam logic [2:0] ST_BAD_END    = 3'd4;
    localparam logic [2:0] ST_BAD_CRC    = 3'd5;

    // Byte kinds decided by the front part
    localparam logic [2:0] KIND_CRC_FIRST = 3'd0;  // start byte: restart CRC
    localparam logic [2:0] KIND_CRC       = 3'd1;  // header or payload byte
    localparam logic [2:0] KIND_CRC_HIGH  = 3'd2;  // received CRC high byte
    localparam logic [2:0] KIND_CRC_LOW   = 3'd3;  // received CRC low byte
    localparam logic [2:0] KIND_END       = 3'd4;  // end byte: final verdict
    localparam logic [2:0] KIND_FAIL      = 3'd5;  // early failure verdict

    // Configuration register indexes
    localparam logic [2:0] CFG_START_BYTE = 3'd0;
    localparam logic [2:0] CFG_SENDER_ID  = 3'd1;
    localparam logic [2:0] CFG_END_BYTE   = 3'd2;
    localparam logic [2:0] CFG_MIN_LENGTH = 3'd3;
    localparam logic [2:0] CFG_MAX_LENGTH = 3'd4;

    // Framing and CRC constants
    localparam logic [8:0]  HEADER_BYTES  = 9'd4;
    localparam logic [8:0]  FRAME_BYTES   = 9'd7;   // header plus trailer
    localparam logic [8:0]  MAX_FRAME     = 9'd262;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_INIT      = 16'h0000;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_START_BYTE = 8'd2;
    localparam logic [7:0] RST_SENDER_ID  = 8'd0;
    localparam logic [7:0] RST_END_BYTE   = 8'd3;
    localparam logic [8:0] RST_MIN_LENGTH = 9'd7;
    localparam logic [8:0] RST_MAX_LENGTH = 9'd262;

    // Default depth of the front-to-back queue
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] sender_id;
        logic [7:0] end_byte;
        logic [8:0] min_length;
        logic [8:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] status;
        logic [8:0] total;
    } entry_t;

    // CRC-16, polynomial 0x1021, MSB first, one byte per call
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/framed_packet_crc_checker.sv =====
// A verdict passes through the front-to-back queue and the verdict register to m_valid.
// Throughput: one byte per cycle while the queue has room, with a byte-wide CRC update.
// The input stalls only when the front-to-back queue is full behind a stalled verdict.
// Reset (aresetn low, synchronous) clears the queue, the CRC and all packet state,
// loads configuration defaults, and leaves the block waiting for a first byte.
// ----------------------------------------------------------------------------
// framed_packet_crc_checker: framed packet checker with CRC-16
// Front classifies bytes and checks header fields, a short queue decouples
// it from the back, which runs the CRC and issues at most one verdict per packet.
// ----------------------------------------------------------------------------
module framed_packet_crc_checker #(
    parameter int QUEUE_DEPTH = fpcc_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [8:0]  m_total_length
);

    fpcc_pkg::cfg_t   cfg_reg;
    fpcc_pkg::entry_t push_entry;
    fpcc_pkg::entry_t head_entry;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             head_valid;

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte <= fpcc_pkg::RST_START_BYTE;
            cfg_reg.sender_id  <= fpcc_pkg::RST_SENDER_ID;
            cfg_reg.end_byte   <= fpcc_pkg::RST_END_BYTE;
            cfg_reg.min_length <= fpcc_pkg::RST_MIN_LENGTH;
            cfg_reg.max_length <= fpcc_pkg::RST_MAX_LENGTH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fpcc_pkg::CFG_START_BYTE: cfg_reg.start_byte <= cfg_wdata[7:0];
                fpcc_pkg::CFG_SENDER_ID:  cfg_reg.sender_id  <= cfg_wdata[7:0];
                fpcc_pkg::CFG_END_BYTE:   cfg_reg.end_byte   <= cfg_wdata[7:0];
                fpcc_pkg::CFG_MIN_LENGTH: cfg_reg.min_length <= cfg_wdata;
                fpcc_pkg::CFG_MAX_LENGTH: cfg_reg.max_length <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    fpcc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_first_byte (s_first_byte),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    fpcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    fpcc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .end_byte       (cfg_reg.end_byte),
        .head_valid     (head_valid),
        .head_entry     (head_entry),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_total_length (m_total_length)
    );

    // Verdict codes stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= fpcc_pkg::ST_BAD_CRC))
        else $error("verdict code out of range");

    // Reported length stays within the frame limits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_total_length >= fpcc_pkg::FRAME_BYTES &&
                     m_total_length <= fpcc_pkg::MAX_FRAME))
        else $error("reported length out of range");

    // Header failures come before the length byte is known
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == fpcc_pkg::ST_BAD_START ||
                     m_status == fpcc_pkg::ST_BAD_ID))
        |-> (m_total_length == fpcc_pkg::FRAME_BYTES))
        else $error("early failure carries a decoded length");

    // A verdict popped from the queue shows on the output next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && (head_entry.kind == fpcc_pkg::KIND_END ||
                 head_entry.kind == fpcc_pkg::KIND_FAIL)) |=> m_valid)
        else $error("verdict lost between queue and output");

endmodule

// ===== hw/rtl/fpcc_front.sv =====
// ----------------------------------------------------------------------------
// fpcc_front: byte classifier
// Tracks the position inside the packet, checks start byte, sender id and
// length, and hands each relevant byte to the queue tagged with its kind.
// ----------------------------------------------------------------------------
module fpcc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fpcc_pkg::cfg_t       cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_first_byte,
    input  logic                 q_full,
    output logic                 push,
    output fpcc_pkg::entry_t     push_entry
);

    logic [8:0] pos_reg, pos_next;
    logic [7:0] plen_reg, plen_next;
    logic       done_reg, done_next;

    logic       accept;
    logic       active;
    logic [8:0] eff_pos;
    logic [7:0] eff_plen;
    logic [8:0] payload_end;
    logic [8:0] frame_total;
    logic [8:0] len_total;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // A first flag restarts the packet, otherwise bytes after a verdict drop
    assign active      = s_first_byte || !done_reg;
    assign eff_pos     = s_first_byte ? 9'd0 : pos_reg;
    assign eff_plen    = s_first_byte ? 8'd0 : plen_reg;
    assign payload_end = fpcc_pkg::HEADER_BYTES + {1'b0, eff_plen};
    assign frame_total = fpcc_pkg::FRAME_BYTES + {1'b0, eff_plen};
    assign len_total   = fpcc_pkg::FRAME_BYTES + {1'b0, s_data_byte};

    // Classify the byte at its position
    always_comb begin
        pos_next          = pos_reg;
        plen_next         = plen_reg;
        done_next         = done_reg;
        push              = 1'b0;
        push_entry.kind   = fpcc_pkg::KIND_CRC;
        push_entry.data   = s_data_byte;
        push_entry.status = fpcc_pkg::ST_VALID;
        push_entry.total  = frame_total;
        if (accept && active) begin
            push      = 1'b1;
            pos_next  = eff_pos + 9'd1;
            plen_next = eff_plen;
            done_next = 1'b0;
            case (eff_pos)
                9'd0: begin
                    push_entry.kind = fpcc_pkg::KIND_CRC_FIRST;
                    if (s_data_byte != cfg.start_byte) begin
                        push_entry.kind   = fpcc_pkg::KIND_FAIL;
                        push_entry.status = fpcc_pkg::ST_BAD_START;
                        done_next         = 1'b1;
                    end
                end
                9'd1: begin
                    if (s_data_byte != cfg.sender_id) begin
                        push_entry.kind   = fpcc_pkg::KIND_FAIL;
                        push_entry.status = fpcc_pkg::ST_BAD_ID;
                        done_next         = 1'b1;
                    end
                end
                9'd2: begin
                    push_entry.kind = fpcc_pkg::KIND_CRC;
                end
                9'd3: begin
                    plen_next        = s_data_byte;
                    push_entry.total = len_total;
                    if (len_total < cfg.min_length || len_total > cfg.max_length) begin
                        push_entry.kind   = fpcc_pkg::KIND_FAIL;
                        push_entry.status = fpcc_pkg::ST_BAD_LENGTH;
                        done_next         = 1'b1;
                    end
                end
                default: begin
                    if (eff_pos < payload_end) begin
                        push_entry.kind = fpcc_pkg::KIND_CRC;
                    end else if (eff_pos == payload_end) begin
                        push_entry.kind = fpcc_pkg::KIND_CRC_HIGH;
                    end else if (eff_pos == payload_end + 9'd1) begin
                        push_entry.kind = fpcc_pkg::KIND_CRC_LOW;
                    end else begin
                        push_entry.kind = fpcc_pkg::KIND_END;
                        done_next       = 1'b1;
                    end
                end
            endcase
        end
    end

    // Hold packet tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            plen_reg <= '0;
            done_reg <= 1'b1;
        end else begin
            pos_reg  <= pos_next;
            plen_reg <= plen_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== hw/rtl/fpcc_queue.sv =====
// ----------------------------------------------------------------------------
// fpcc_queue: short FIFO between classifier and checker
// Register-based storage; head entry is visible whenever the queue is not
// empty.
// ----------------------------------------------------------------------------
module fpcc_queue #(
    parameter int DEPTH = fpcc_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fpcc_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output fpcc_pkg::entry_t  head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fpcc_pkg::entry_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries; payload needs no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/fpcc_back.sv =====
// ----------------------------------------------------------------------------
// fpcc_back: CRC engine and verdict stage
// Runs the byte-wide CRC, compares the received CRC, checks the end byte
// and holds the verdict in an output register until it is taken.
// ----------------------------------------------------------------------------
module fpcc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        end_byte,
    input  logic              head_valid,
    input  fpcc_pkg::entry_t  head_entry,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [8:0]        m_total_length
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic        mismatch_reg, mismatch_next;
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [8:0]  total_reg, total_next;

    logic        needs_out;
    logic        out_free;

    assign needs_out = (head_entry.kind == fpcc_pkg::KIND_END) ||
                       (head_entry.kind == fpcc_pkg::KIND_FAIL);
    assign out_free  = !m_valid_reg || m_ready;
    assign pop       = head_valid && (!needs_out || out_free);

    // Carry out the head entry
    always_comb begin
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        mismatch_next = mismatch_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        status_next   = status_reg;
        total_next    = total_reg;
        if (pop) begin
            case (head_entry.kind)
                fpcc_pkg::KIND_CRC_FIRST: begin
                    crc_next = fpcc_pkg::crc_update(fpcc_pkg::CRC_INIT, head_entry.data);
                end
                fpcc_pkg::KIND_CRC: begin
                    crc_next = fpcc_pkg::crc_update(crc_reg, head_entry.data);
                end
                fpcc_pkg::KIND_CRC_HIGH: begin
                    crc_high_next = head_entry.data;
                end
                fpcc_pkg::KIND_CRC_LOW: begin
                    mismatch_next = (crc_high_reg != crc_reg[15:8]) ||
                                    (head_entry.data != crc_reg[7:0]);
                end
                fpcc_pkg::KIND_END: begin
                    m_valid_next = 1'b1;
                    total_next   = head_entry.total;
                    if (head_entry.data != end_byte) begin
                        status_next = fpcc_pkg::ST_BAD_END;
                    end else if (mismatch_reg) begin
                        status_next = fpcc_pkg::ST_BAD_CRC;
                    end else begin
                        status_next = fpcc_pkg::ST_VALID;
                    end
                end
                fpcc_pkg::KIND_FAIL: begin
                    m_valid_next = 1'b1;
                    status_next  = head_entry.status;
                    total_next   = head_entry.total;
                end
                default: begin
                    crc_next = crc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg      <= fpcc_pkg::CRC_INIT;
            crc_high_reg <= '0;
            mismatch_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            crc_reg      <= crc_next;
            crc_high_reg <= crc_high_next;
            mismatch_reg <= mismatch_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Hold the verdict payload
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        total_reg  <= total_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_total_length = total_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the framed packet CRC checker
// Runs a short stimulus table and then random framed packets. Most packets
// are well formed; others carry a bad start, id, length, end byte or CRC, or
// are cut short. A local packet checker predicts the verdicts not typed in the table. The run
// moves through several register settings and several idle and stall
// patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 4;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int MIN_PACKETS  = 1;
    localparam int DRAIN_CYCLES = 4 * (fpcc_pkg::QUEUE_DEPTH + 2);
    localparam int RUN_LIMIT_NS = 5_000_000;

    // Byte positions within the header
    localparam logic [8:0] POS_START = 9'd0;
    localparam logic [8:0] POS_ID    = 9'd1;
    localparam logic [8:0] POS_CMD   = 9'd2;
    localparam logic [8:0] POS_LEN   = 9'd3;

    typedef struct packed {
        logic [2:0] status;
        logic [8:0] total;
    } verdict_t;

    // How a table row gets its byte: as typed, or from the running CRC
    typedef enum logic [1:0] {
        ROW_DATA,
        ROW_CRC_HI,
        ROW_CRC_LO,
        ROW_CRC_LO_BAD
    } row_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        row_kind_t  kind;
        logic       fixed;      // verdict typed in the row
        logic       fixed_hit;  // the typed row expects a verdict
        logic [2:0] status;
        logic [8:0] total;
    } stim_row_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       cfg_wr_en      = 1'b0;
    logic [2:0] cfg_index      = fpcc_pkg::CFG_START_BYTE;
    logic [8:0] cfg_wdata      = '0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte    = '0;
    logic       s_first_byte   = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [2:0] m_status;
    logic [8:0] m_total_length;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int mismatch_count  = 0;
    int phase_items     = 0;
    int phase_packets   = 0;

    verdict_t  verdict_q[$];
    stim_row_t stim_rows[$];

    // Local copy of the checker registers and packet state
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_id;
    logic [7:0]  cfg_end;
    logic [8:0]  cfg_min;
    logic [8:0]  cfg_max;
    logic [15:0] crc_acc;
    logic [8:0]  pkt_pos;
    logic [7:0]  pkt_payload;
    logic [7:0]  crc_hi_rx;
    logic        crc_bad;
    logic        pkt_idle;

    framed_packet_crc_checker u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_first_byte   (s_first_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_total_length (m_total_length)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // Bit-serial CRC-16, polynomial 0x1021, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ fpcc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [8:0] d);
        case (idx)
            fpcc_pkg::CFG_START_BYTE: cfg_start = d[7:0];
            fpcc_pkg::CFG_SENDER_ID:  cfg_id    = d[7:0];
            fpcc_pkg::CFG_END_BYTE:   cfg_end   = d[7:0];
            fpcc_pkg::CFG_MIN_LENGTH: cfg_min   = d;
            fpcc_pkg::CFG_MAX_LENGTH: cfg_max   = d;
            default: ;
        endcase
    endfunction

    // Advance the packet state by one byte; return 1 when a verdict is due
    function automatic logic step_checker(input logic [7:0] b, input logic f,
                                          output verdict_t v, output logic took);
        logic [8:0] pos;
        logic [8:0] pay_end;
        logic [8:0] tot;
        logic [2:0] st;
        logic       found;
        found    = 1'b0;
        st       = fpcc_pkg::ST_VALID;
        took     = 1'b1;
        v.status = fpcc_pkg::ST_VALID;
        v.total  = fpcc_pkg::FRAME_BYTES;
        if (f) begin
            crc_acc     = fpcc_pkg::CRC_INIT;
            pkt_pos     = '0;
            pkt_payload = '0;
            crc_hi_rx   = '0;
            crc_bad     = 1'b0;
            pkt_idle    = 1'b0;
        end else if (pkt_idle) begin
            took = 1'b0;
            return 1'b0;
        end
        pos     = pkt_pos;
        pay_end = fpcc_pkg::HEADER_BYTES + {1'b0, pkt_payload};
        tot     = fpcc_pkg::FRAME_BYTES + {1'b0, pkt_payload};
        pkt_pos = pkt_pos + 9'd1;
        if (pos == POS_START) begin
            crc_acc = crc16_byte(crc_acc, b);
            if (b != cfg_start) begin
                found = 1'b1;
                st    = fpcc_pkg::ST_BAD_START;
                tot   = fpcc_pkg::FRAME_BYTES;
            end
        end else if (pos == POS_ID) begin
            crc_acc = crc16_byte(crc_acc, b);
            if (b != cfg_id) begin
                found = 1'b1;
                st    = fpcc_pkg::ST_BAD_ID;
                tot   = fpcc_pkg::FRAME_BYTES;
            end
        end else if (pos == POS_CMD) begin
            crc_acc = crc16_byte(crc_acc, b);
        end else if (pos == POS_LEN) begin
            crc_acc     = crc16_byte(crc_acc, b);
            pkt_payload = b;
            tot         = fpcc_pkg::FRAME_BYTES + {1'b0, b};
            if (tot < cfg_min || tot > cfg_max) begin
                found = 1'b1;
                st    = fpcc_pkg::ST_BAD_LENGTH;
            end
        end else if (pos < pay_end) begin
            crc_acc = crc16_byte(crc_acc, b);
        end else if (pos == pay_end) begin
            crc_hi_rx = b;
        end else if (pos == pay_end + 9'd1) begin
            crc_bad = (crc_hi_rx != crc_acc[15:8]) || (b != crc_acc[7:0]);
        end else begin
            // End byte: end value first, CRC second
            found = 1'b1;
            if (b != cfg_end) begin
                st = fpcc_pkg::ST_BAD_END;
            end else if (crc_bad) begin
                st = fpcc_pkg::ST_BAD_CRC;
            end else begin
                st = fpcc_pkg::ST_VALID;
            end
        end
        if (found) begin
            pkt_idle = 1'b1;
            v.status = st;
            v.total  = tot;
        end
        return found;
    endfunction

    function automatic void add_row(input logic [7:0] d, input logic f, input row_kind_t k,
                                    input logic fx, input logic fh,
                                    input logic [2:0] st, input logic [8:0] tot);
        stim_row_t r;
        r.data      = d;
        r.first     = f;
        r.kind      = k;
        r.fixed     = fx;
        r.fixed_hit = fh;
        r.status    = st;
        r.total     = tot;
        stim_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Hold one byte on the input until its transfer, then predict it
    task automatic transfer_byte(input logic [7:0] d, input logic f,
                                 output logic hit, output logic took, output verdict_t v);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= d;
        s_first_byte <= f;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        hit = step_checker(d, f, v, took);
    endtask

    task automatic push_byte(input logic [7:0] d, input logic f);
        logic     hit;
        logic     took;
        verdict_t v;
        transfer_byte(d, f, hit, took, v);
        if (hit) begin
            verdict_q.push_back(v);
        end
        if (took) begin
            phase_items++;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        apply_reg(idx, d);
    endtask

    // Write all registers; the spare bit of the byte registers is random
    task automatic program_regs(input logic [7:0] sb, input logic [7:0] idb,
                                input logic [7:0] eb, input logic [8:0] mn,
                                input logic [8:0] mx);
        logic [2:0] spare_idx;
        write_reg(fpcc_pkg::CFG_START_BYTE, {1'($urandom_range(1)), sb});
        write_reg(fpcc_pkg::CFG_SENDER_ID,  {1'($urandom_range(1)), idb});
        write_reg(fpcc_pkg::CFG_END_BYTE,   {1'($urandom_range(1)), eb});
        write_reg(fpcc_pkg::CFG_MIN_LENGTH, mn);
        write_reg(fpcc_pkg::CFG_MAX_LENGTH, mx);
        // Unused indexes must leave every register alone
        if ($urandom_range(1)) begin
            spare_idx = fpcc_pkg::CFG_MAX_LENGTH + 3'($urandom_range(1, 3));
            write_reg(spare_idx, 9'($urandom));
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Drop valid, wait for every verdict, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Send one random packet, mostly well formed, sometimes broken or cut short
    task automatic send_packet();
        int         pick;
        int         lo_p;
        int         hi_p;
        int         plen;
        int         span;
        int         cut;
        int         sent;
        logic [7:0] sb;
        logic [7:0] idb;
        logic [7:0] eb;
        logic [7:0] hi_b;
        logic [7:0] lo_b;
        logic [7:0] body[$];

        // Insert stray bytes without a first flag
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
        end

        pick = $urandom_range(99);
        lo_p = int'(cfg_min) - 7;
        hi_p = int'(cfg_max) - 7;
        if (lo_p < 0) lo_p = 0;
        if (lo_p > 255) lo_p = 255;
        if (hi_p > 255) hi_p = 255;

        // Pick a payload length, mostly short and inside the limits
        if (lo_p <= hi_p) begin
            span = hi_p - lo_p;
            if ($urandom_range(9) == 0) begin
                plen = $urandom_range(lo_p, hi_p);
            end else begin
                plen = lo_p + $urandom_range(0, (span < 6) ? span : 6);
            end
        end else begin
            plen = $urandom_range(0, 6);
        end
        if (pick >= 12 && pick < 20) begin
            if (lo_p > 0) begin
                plen = lo_p - 1 - $urandom_range(0, (lo_p - 1 < 3) ? lo_p - 1 : 3);
            end else if (hi_p < 255) begin
                plen = hi_p + 1 + $urandom_range(0, (254 - hi_p < 3) ? 254 - hi_p : 3);
            end
        end

        sb  = cfg_start;
        idb = cfg_id;
        eb  = cfg_end;
        if (pick < 6) begin
            sb = sb ^ 8'($urandom_range(1, 255));
        end else if (pick < 12) begin
            idb = idb ^ 8'($urandom_range(1, 255));
        end
        if ((pick >= 36 && pick < 46)) begin
            eb = eb ^ 8'($urandom_range(1, 255));
        end

        body.push_back(sb);
        body.push_back(idb);
        body.push_back(8'($urandom));
        body.push_back(8'(plen));
        repeat (plen) body.push_back(8'($urandom));

        // A cut packet is dropped by the first flag of the next one
        cut = -1;
        if (pick >= 20 && pick < 28) begin
            cut = $urandom_range(1, plen + 6);
        end

        sent = 0;
        foreach (body[i]) begin
            if (sent == cut) return;
            push_byte(body[i], i == 0);
            sent++;
        end
        phase_packets++;
        hi_b = crc_acc[15:8];
        lo_b = crc_acc[7:0];
        if ((pick >= 28 && pick < 36) || (pick >= 42 && pick < 46)) begin
            if ($urandom_range(1)) begin
                hi_b = hi_b ^ 8'($urandom_range(1, 255));
            end else begin
                lo_b = lo_b ^ 8'($urandom_range(1, 255));
            end
        end
        if (sent == cut) return;
        push_byte(hi_b, 1'b0);
        sent++;
        if (sent == cut) return;
        push_byte(lo_b, 1'b0);
        sent++;
        if (sent == cut) return;
        push_byte(eb, 1'b0);
    endtask

    // Compare each verdict transfer with the oldest prediction; drive stalls
    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict with none pending: status %0d length %0d",
                                          m_status, m_total_length));
            end else begin
                want = verdict_q.pop_front();
                if (m_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              m_status, want.status));
                end
                if (m_total_length !== want.total) begin
                    report_mismatch($sformatf("total_length %0d, predicted %0d",
                                              m_total_length, want.total));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("framed_packet_crc_checker verification failed");
        $finish;
    end

    initial begin
        logic       hit;
        logic       took;
        verdict_t   v;
        logic [7:0] d;
        logic [8:0] mn;
        logic [8:0] mx;
        stim_row_t  row;

        // Registers and packet state after reset
        cfg_start   = fpcc_pkg::RST_START_BYTE;
        cfg_id      = fpcc_pkg::RST_SENDER_ID;
        cfg_end     = fpcc_pkg::RST_END_BYTE;
        cfg_min     = fpcc_pkg::RST_MIN_LENGTH;
        cfg_max     = fpcc_pkg::RST_MAX_LENGTH;
        crc_acc     = fpcc_pkg::CRC_INIT;
        pkt_pos     = '0;
        pkt_payload = '0;
        crc_hi_rx   = '0;
        crc_bad     = 1'b0;
        pkt_idle    = 1'b1;

        // Directed table under the reset register values
        // stray byte while waiting, bad start, stray byte after a verdict
        add_row(8'hFF, 1'b0, ROW_DATA,       1'b1, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b1, ROW_DATA,       1'b1, 1'b1, fpcc_pkg::ST_BAD_START,  9'd7);
        add_row(8'h02, 1'b0, ROW_DATA,       1'b1, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        // bad id
        add_row(8'h02, 1'b1, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'hFF, 1'b0, ROW_DATA,       1'b1, 1'b1, fpcc_pkg::ST_BAD_ID,     9'd7);
        // packet dropped by a new first flag
        add_row(8'h02, 1'b1, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        // shortest valid packet
        add_row(8'h02, 1'b1, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h5A, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_CRC_HI,     1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_CRC_LO,     1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h03, 1'b0, ROW_DATA,       1'b1, 1'b1, fpcc_pkg::ST_VALID,      9'd7);
        // bad end byte over a good CRC
        add_row(8'h02, 1'b1, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'hFF, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h01, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h80, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_CRC_HI,     1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_CRC_LO,     1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'hFC, 1'b0, ROW_DATA,       1'b1, 1'b1, fpcc_pkg::ST_BAD_END,    9'd8);
        // bad CRC low byte
        add_row(8'h02, 1'b1, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_DATA,       1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_CRC_HI,     1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h00, 1'b0, ROW_CRC_LO_BAD, 1'b0, 1'b0, fpcc_pkg::ST_VALID,      9'd0);
        add_row(8'h03, 1'b0, ROW_DATA,       1'b1, 1'b1, fpcc_pkg::ST_BAD_CRC,    9'd7);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the table; typed rows override the prediction
        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            case (row.kind)
                ROW_CRC_HI:     d = crc_acc[15:8];
                ROW_CRC_LO:     d = crc_acc[7:0];
                ROW_CRC_LO_BAD: d = ~crc_acc[7:0];
                default:        d = row.data;
            endcase
            transfer_byte(d, row.first, hit, took, v);
            if (row.fixed) begin
                if (row.fixed_hit) begin
                    v.status = row.status;
                    v.total  = row.total;
                    verdict_q.push_back(v);
                end
            end else if (hit) begin
                verdict_q.push_back(v);
            end
        end

        // Random phases, each with its own registers and one of four idle and stall patterns
        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle();
            case (p)
                0: program_regs(fpcc_pkg::RST_START_BYTE, fpcc_pkg::RST_SENDER_ID,
                                fpcc_pkg::RST_END_BYTE, fpcc_pkg::RST_MIN_LENGTH,
                                fpcc_pkg::RST_MAX_LENGTH);
                1: program_regs(8'h00, 8'hFF, 8'hFF, 9'd7, 9'd7);
                2: program_regs(8'hFF, 8'h00, 8'h00, 9'd10, 9'd20);
                3: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 9'd8, 9'd16);
                4: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 9'd262, 9'd262);
                5: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 9'd20, 9'd10);
                6: begin
                    mn = 9'(7 + $urandom_range(0, 40));
                    mx = 9'(mn + $urandom_range(0, 30));
                    program_regs(8'($urandom), 8'($urandom), 8'($urandom), mn, mx);
                end
                default: program_regs(8'hAA, 8'h55, 8'h7E, 9'd12, 9'd12);
            endcase
            case (p % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 85;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 85;
                end
                default: begin
                    sender_idle_pct = 10;
                    recv_stall_pct  = 10;
                end
            endcase
            phase_items   = 0;
            phase_packets = 0;
            while (phase_items < PHASE_ITEMS || phase_packets < MIN_PACKETS) begin
                send_packet();
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("framed_packet_crc_checker verification clean");
        end else begin
            $display("framed_packet_crc_checker verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/fpcc_pkg.sv
hw/rtl/fpcc_front.sv
hw/rtl/fpcc_queue.sv
hw/rtl/fpcc_back.sv
hw/rtl/framed_packet_crc_checker.sv
tb/testbench.sv
